FILE: src/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, sampled at clk, off while reset is active.
`define DSAQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define DSAQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dsaq_pkg.sv
// Types and constants of the deadline sorted alarm queue.
// No dependencies.
package dsaq_pkg;

  localparam int TIME_W  = 48;
  localparam int DELAY_W = 16;
  localparam int TAG_W   = 8;
  localparam int KIND_W  = 2;

  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;

  typedef struct packed {
    logic accept;
    logic emit_ins;
    logic emit_pop;
    logic pop_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic head_due;
    logic next_due;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/dsaq_ctrl.sv
// Controller of the alarm queue: input handshake, insert and expiry sequencing.
// Depends on dsaq_pkg.
module dsaq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  dsaq_pkg::dp_stat_t stat,
  output dsaq_pkg::ctl_cmd_t cmd
);
  import dsaq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          n_nxt      = '0;
          state_nxt  = (in_mode == MODE_TICK) ? ST_POP : ST_INS;
        end
      end
      ST_INS: begin
        if (stat.out_free) begin
          cmd.emit_ins = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_POP: begin
        if (!stat.head_due) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_pop = 1'b1;
          cmd.pop_last = (n_r == RES_CNT_W'(MAX_RESULTS - 1)) || !stat.next_due;
          n_nxt        = n_r + RES_CNT_W'(1);
          if (cmd.pop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

FILE: src/dsaq_dpath.sv
// Datapath of the alarm queue: time counter, sorted entry cells, result register.
// Depends on dsaq_pkg.
module dsaq_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_mode,
  input  logic [dsaq_pkg::DELAY_W-1:0]        in_alarm_delay,
  input  logic [dsaq_pkg::TAG_W-1:0]          in_alarm_tag,
  input  dsaq_pkg::ctl_cmd_t                  cmd,
  output dsaq_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dsaq_pkg::KIND_W-1:0]         out_result_kind,
  output logic [dsaq_pkg::TAG_W-1:0]          out_expired_tag,
  output logic [dsaq_pkg::DELAY_W-1:0]        out_expired_delay,
  output logic                                out_last
);
  import dsaq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [TIME_W-1:0]  time_now_r;
  logic [CNT_W-1:0]   count_r;
  logic [TAG_W-1:0]   tag_r;
  logic [DELAY_W-1:0] delay_r;
  logic [TIME_W-1:0]  dl_new_r;

  logic [TIME_W-1:0]  ent_dl_r  [QUEUE_DEPTH];
  logic [TAG_W-1:0]   ent_tag_r [QUEUE_DEPTH];
  logic [DELAY_W-1:0] ent_dly_r [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] ge;
  logic                   do_ins;

  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [DELAY_W-1:0] out_delay_r;
  logic               out_last_r;

  assign stat.full     = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign stat.head_due = (count_r != '0) && (ent_dl_r[0] <= time_now_r);
  assign stat.next_due = (count_r > CNT_W'(1)) && (ent_dl_r[1] <= time_now_r);
  assign stat.out_free = !out_valid_r || out_ready;

  assign do_ins = cmd.emit_ins && !stat.full;

  // ge marks cells at or after the insert point; empty cells count as later
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (count_r <= CNT_W'(i)) || (ent_dl_r[i] >= dl_new_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r <= '0;
      count_r    <= '0;
    end else begin
      if (cmd.accept && (in_mode == MODE_TICK)) begin
        time_now_r <= time_now_r + TIME_W'(1);
      end
      if (do_ins) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.emit_pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_r    <= in_alarm_tag;
      delay_r  <= in_alarm_delay;
      dl_new_r <= time_now_r + TIME_W'(in_alarm_delay);
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic ins_here;
    if (g == 0) begin : g_head
      assign ins_here = ge[g];
    end else begin : g_body
      assign ins_here = ge[g] && !ge[g-1];
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (ins_here) begin
          ent_dl_r[g]  <= dl_new_r;
          ent_tag_r[g] <= tag_r;
          ent_dly_r[g] <= delay_r;
        end else if (ge[g] && (g > 0)) begin
          ent_dl_r[g]  <= ent_dl_r[(g > 0) ? g - 1 : 0];
          ent_tag_r[g] <= ent_tag_r[(g > 0) ? g - 1 : 0];
          ent_dly_r[g] <= ent_dly_r[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd.emit_pop && (g < QUEUE_DEPTH - 1)) begin
        ent_dl_r[g]  <= ent_dl_r[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        ent_tag_r[g] <= ent_tag_r[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        ent_dly_r[g] <= ent_dly_r[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ins || cmd.emit_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ins) begin
      out_kind_r  <= stat.full ? KIND_REJECT : KIND_ACCEPT;
      out_tag_r   <= tag_r;
      out_delay_r <= delay_r;
      out_last_r  <= 1'b1;
    end else if (cmd.emit_pop) begin
      out_kind_r  <= KIND_EXPIRE;
      out_tag_r   <= ent_tag_r[0];
      out_delay_r <= ent_dly_r[0];
      out_last_r  <= cmd.pop_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_expired_tag   = out_tag_r;
  assign out_expired_delay = out_delay_r;
  assign out_last          = out_last_r;

endmodule

FILE: src/deadline_sorted_alarm_queue.sv
// Insert: accepted in idle, result word loaded once the output register is free; no new
// item is taken until then. Tick: accepted, then up to 16 expired alarms are popped, one
// head pop per cycle via the entry shift cells while output is free; none due frees input.
// Results wait in one output register; back pressure stalls the insert answer and each pop.
// Reset (synchronous, rst_n low) clears time and entry count; entry cells are not cleared.
module deadline_sorted_alarm_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [dsaq_pkg::DELAY_W-1:0] in_alarm_delay,
  input  logic [dsaq_pkg::TAG_W-1:0]   in_alarm_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dsaq_pkg::KIND_W-1:0]  out_result_kind,
  output logic [dsaq_pkg::TAG_W-1:0]   out_expired_tag,
  output logic [dsaq_pkg::DELAY_W-1:0] out_expired_delay,
  output logic                         out_last
);
  import dsaq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  dsaq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsaq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_alarm_delay    (in_alarm_delay),
    .in_alarm_tag      (in_alarm_tag),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_expired_tag   (out_expired_tag),
    .out_expired_delay (out_expired_delay),
    .out_last          (out_last)
  );

endmodule

FILE: src/dsaq_checker.sv
// Port-level checker for the alarm queue, bound to the top level.
// Depends on dsaq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsaq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dsaq_pkg::KIND_W-1:0]  out_result_kind,
  input logic [dsaq_pkg::TAG_W-1:0]   out_expired_tag,
  input logic                         out_last
);
  import dsaq_pkg::*;

  `DSAQ_ASSERT(a_kind_legal, clk, rst_n, !out_valid || (out_result_kind == KIND_ACCEPT) || (out_result_kind == KIND_REJECT) || (out_result_kind == KIND_EXPIRE), "illegal result kind")
  `DSAQ_ASSERT(a_ins_last, clk, rst_n, !out_valid || (out_result_kind == KIND_EXPIRE) || out_last, "insert answer without last")
  `DSAQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input ready right after accept")
  `DSAQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_expired_tag) && $stable(out_last), "stalled result word changed")

endmodule

bind deadline_sorted_alarm_queue dsaq_checker u_dsaq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_expired_tag (out_expired_tag),
  .out_last        (out_last)
);

FILE: verif/tb_top.sv
// Testbench for deadline_sorted_alarm_queue: a queue-fed driver, an output monitor and a
// predictor of the deadline-sorted alarm store. Each result word is checked field by field.
// Depends on dsaq_pkg and the deadline_sorted_alarm_queue RTL.
`timescale 1ns / 1ps

module tb_top;
  import dsaq_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 24;
  localparam int WORD_TARGET = 330;

  typedef struct {
    logic                mode;
    logic [DELAY_W-1:0]  dly;
    logic [TAG_W-1:0]    tag;
    bit                  hold;
    int                  phase;
  } alarm_word_t;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
    logic [DELAY_W-1:0]  dly;
    logic                last;
  } alarm_report_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_mode;
  logic [DELAY_W-1:0]  in_alarm_delay;
  logic [TAG_W-1:0]    in_alarm_tag;
  logic                out_valid;
  logic                out_ready;
  logic [KIND_W-1:0]   out_result_kind;
  logic [TAG_W-1:0]    out_expired_tag;
  logic [DELAY_W-1:0]  out_expired_delay;
  logic                out_last;

  alarm_word_t   alarm_words[$];
  alarm_report_t expected_reports[$];

  // predictor state
  logic [TIME_W-1:0]   clock_now;
  logic [TIME_W-1:0]   sched_deadline[QDEPTH];
  logic [TAG_W-1:0]    sched_tag[QDEPTH];
  logic [DELAY_W-1:0]  sched_delay[QDEPTH];
  int                  sched_count;

  logic in_taken;
  int   cur_phase;
  int   idle_cycles;
  int   mismatch_cnt;
  int   accepted_cnt, rejected_cnt, expired_cnt, widest_tick, words_taken;

  deadline_sorted_alarm_queue #(.QUEUE_DEPTH(QDEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_alarm_delay   (in_alarm_delay),
    .in_alarm_tag     (in_alarm_tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_expired_tag  (out_expired_tag),
    .out_expired_delay(out_expired_delay),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_pct(input int ph, input bit sender);
    case (ph)
      0: return sender ? 16 : 57;
      1: return sender ? 57 : 16;
      default: return 0;
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay(input logic [DELAY_W-1:0] tie);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return DELAY_W'($urandom_range(0, 8));
    if (r < 75) return tie;
    if (r < 97) return DELAY_W'($urandom_range(9, 120));
    return DELAY_W'($urandom_range(0, 65535));
  endfunction

  task automatic push_word(input logic mode, input logic [DELAY_W-1:0] dly,
                           input logic [TAG_W-1:0] tag);
    alarm_word_t w;
    w.mode  = mode;
    w.dly   = dly;
    w.tag   = tag;
    w.hold  = 1'b0;
    w.phase = 0;
    alarm_words.push_back(w);
  endtask

  task automatic advance_alarm_queue(input logic mode, input logic [DELAY_W-1:0] dly,
                                     input logic [TAG_W-1:0] tag);
    logic [TIME_W-1:0] dl;
    alarm_report_t     rep;
    int                pos, i, n;
    if (mode == MODE_INSERT) begin
      rep.tag  = tag;
      rep.dly  = dly;
      rep.last = 1'b1;
      if (sched_count >= QDEPTH) begin
        rep.kind = KIND_REJECT;
        rejected_cnt++;
      end else begin
        dl  = clock_now + TIME_W'(dly);
        pos = 0;
        while (pos < sched_count && sched_deadline[pos] < dl) pos++;
        for (i = sched_count; i > pos; i--) begin
          sched_deadline[i] = sched_deadline[i-1];
          sched_tag[i]      = sched_tag[i-1];
          sched_delay[i]    = sched_delay[i-1];
        end
        sched_deadline[pos] = dl;
        sched_tag[pos]      = tag;
        sched_delay[pos]    = dly;
        sched_count++;
        rep.kind = KIND_ACCEPT;
        accepted_cnt++;
      end
      expected_reports.push_back(rep);
    end else begin
      clock_now = clock_now + 1'b1;
      n = 0;
      while (n < MAX_RESULTS && sched_count > 0 && sched_deadline[0] <= clock_now) begin
        rep.kind = KIND_EXPIRE;
        rep.tag  = sched_tag[0];
        rep.dly  = sched_delay[0];
        rep.last = 1'b0;
        expected_reports.push_back(rep);
        for (i = 1; i < sched_count; i++) begin
          sched_deadline[i-1] = sched_deadline[i];
          sched_tag[i-1]      = sched_tag[i];
          sched_delay[i-1]    = sched_delay[i];
        end
        sched_count--;
        n++;
      end
      if (n > 0) expected_reports[expected_reports.size()-1].last = 1'b1;
      expired_cnt += n;
      if (n > widest_tick) widest_tick = n;
    end
  endtask

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatch_cnt++;
  endtask

  // driver
  always @(negedge clk) begin
    alarm_word_t w;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (alarm_words.size() != 0
            && !(alarm_words[0].hold && expected_reports.size() != 0)
            && $urandom_range(0, 99) >= gap_pct(alarm_words[0].phase, 1'b1)) begin
          w = alarm_words.pop_front();
          in_valid       <= 1'b1;
          in_mode        <= w.mode;
          in_alarm_delay <= w.dly;
          in_alarm_tag   <= w.tag;
          cur_phase      <= w.phase;
        end else begin
          in_valid       <= 1'b0;
          in_mode        <= 1'($urandom_range(0, 1));
          in_alarm_delay <= DELAY_W'($urandom_range(0, 65535));
          in_alarm_tag   <= TAG_W'($urandom_range(0, 255));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= gap_pct(cur_phase, 1'b0));
    end
  end

  // monitor
  always @(posedge clk) begin
    alarm_report_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        words_taken++;
        advance_alarm_queue(in_mode, in_alarm_delay, in_alarm_tag);
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result word, kind %0d tag %0h delay %0d last %0b",
                   $time, out_result_kind, out_expired_tag, out_expired_delay, out_last);
          mismatch_cnt++;
        end else begin
          want = expected_reports.pop_front();
          if (want.kind !== out_result_kind) flag_field("kind", want.kind, out_result_kind);
          if (want.tag !== out_expired_tag) flag_field("tag", want.tag, out_expired_tag);
          if (want.dly !== out_expired_delay) flag_field("delay", want.dly, out_expired_delay);
          if (want.last !== out_last) flag_field("last", want.last, out_last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("** deadline_sorted_alarm_queue: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i, n, r, ph, prev_ph;
    logic [DELAY_W-1:0] tie;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_INSERT;
    in_alarm_delay = '0;
    in_alarm_tag   = '0;
    out_ready      = 1'b0;
    cur_phase      = 0;
    idle_cycles    = 0;
    mismatch_cnt   = 0;
    accepted_cnt   = 0;
    rejected_cnt   = 0;
    expired_cnt    = 0;
    widest_tick    = 0;
    words_taken    = 0;
    clock_now      = '0;
    sched_count    = 0;

    // tick on empty queue, equal deadlines, several due at one tick
    push_word(MODE_TICK, 16'd0, 8'h00);
    push_word(MODE_INSERT, 16'd0, 8'h00);
    push_word(MODE_INSERT, 16'd0, 8'hFF);
    push_word(MODE_INSERT, 16'd1, 8'h01);
    push_word(MODE_INSERT, 16'd3, 8'h5A);
    push_word(MODE_TICK, 16'd0, 8'h00);
    // fill to full with one shared deadline, then overflow
    for (i = 0; i < QDEPTH - 1; i++) push_word(MODE_INSERT, 16'd2, TAG_W'(8'h10 + i));
    push_word(MODE_INSERT, 16'd2, 8'hEE);
    push_word(MODE_TICK, 16'd0, 8'h00);
    push_word(MODE_TICK, 16'd0, 8'h00);
    push_word(MODE_INSERT, 16'hFFFF, 8'hA5);
    alarm_words[23].hold = 1'b1;
    i = alarm_words.size();

    while (alarm_words.size() < WORD_TARGET) begin
      r   = $urandom_range(0, 9);
      tie = DELAY_W'($urandom_range(0, 12));
      if (r < 5) begin
        n = $urandom_range(1, 5);
        repeat (n) push_word(MODE_INSERT, pick_delay(tie), TAG_W'($urandom_range(0, 255)));
        n = $urandom_range(1, 6);
        repeat (n) push_word(MODE_TICK, DELAY_W'($urandom_range(0, 65535)),
                             TAG_W'($urandom_range(0, 255)));
      end else if (r == 5) begin
        repeat (18) push_word(MODE_INSERT, DELAY_W'($urandom_range(0, 6)),
                              TAG_W'($urandom_range(0, 255)));
        repeat (8) push_word(MODE_TICK, 16'd0, 8'h00);
      end else if (r < 8) begin
        n = $urandom_range(1, 12);
        repeat (n) push_word(MODE_TICK, DELAY_W'($urandom_range(0, 65535)),
                             TAG_W'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) push_word(1'($urandom_range(0, 1)), pick_delay(tie),
                             TAG_W'($urandom_range(0, 255)));
      end
    end
    alarm_words[i].hold = 1'b1;

    prev_ph = 0;
    for (i = 0; i < alarm_words.size(); i++) begin
      ph = i * 3 / alarm_words.size();
      alarm_words[i].phase = ph;
      if (ph != prev_ph) alarm_words[i].hold = 1'b1;
      prev_ph = ph;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (alarm_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_reports.size() != 0) begin
      $display("%0d expected result words never arrived", expected_reports.size());
      mismatch_cnt++;
    end
    $display("Run: %0d words sent, %0d alarms accepted, %0d rejected on full queue,",
             words_taken, accepted_cnt, rejected_cnt);
    $display("     %0d expired, up to %0d in one tick; %0d mismatches",
             expired_cnt, widest_tick, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("** deadline_sorted_alarm_queue: PASSED **");
    end else begin
      $display("** deadline_sorted_alarm_queue: FAILED **");
    end
    $finish;
  end

endmodule
